@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the fraction reduction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/drf_pkg.sv @@
// Package with widths, constants and interface types of the fraction reduction block.
package drf_pkg;

	localparam int VALUE_W       = 32;
	localparam int NUM_W         = 36;
	localparam int DEN_W         = 20;
	localparam int MAG_W         = 35;
	localparam int CNT_W         = $clog2(NUM_W + 1);
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [DEN_W-1:0] SCALE_RESET = DEN_W'(100000);
	localparam logic [NUM_W-1:0] MAG_MAX     = {{(NUM_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

	typedef struct packed {
		logic             start;
		logic             short_op;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ hw/rtl/drf_div.sv @@
// Shared restoring divider that produces one quotient bit per cycle.
`include "assert_macros.svh"

module drf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  drf_pkg::div_req_t req,
	output drf_pkg::div_rsp_t rsp
);
	import drf_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= req.short_op ? CNT_W'(DEN_W) : CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			div_q <= req.divisor;
			quo_q <= req.short_op ? (req.dividend << (NUM_W - DEN_W)) : req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	`ASSERT_NEVER(a_start_busy, req.start && busy_q, "divider started while busy")
	`ASSERT_CLK(a_rem_lt_div, done_q |-> (rem_q < div_q), "remainder not below divisor")

endmodule

@@ hw/rtl/drf_seq.sv @@
// Sequencer that runs the Euclid loop and the two reductions on the shared divider.
`include "assert_macros.svh"

module drf_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [drf_pkg::NUM_W-1:0] scaled,
	input  logic [drf_pkg::DEN_W-1:0] scale,
	output logic                      done,
	output logic [drf_pkg::NUM_W-1:0] num_mag,
	output logic [drf_pkg::DEN_W-1:0] den
);
	import drf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_QN   = 2'd2;
	localparam logic [1:0] S_QD   = 2'd3;

	logic [1:0]       state_q;
	logic             done_q;
	logic             req_start_q;
	logic             req_short_q;
	logic [NUM_W-1:0] req_dividend_q;
	logic [DEN_W-1:0] req_divisor_q;
	div_req_t         req;
	div_rsp_t         rsp;
	logic [NUM_W-1:0] scaled_q;
	logic [DEN_W-1:0] scale_q;
	logic [DEN_W-1:0] y_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	assign req = '{start: req_start_q, short_op: req_short_q,
		dividend: req_dividend_q, divisor: req_divisor_q};

	drf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			req_start_q <= 1'b0;
		end else begin
			done_q      <= (state_q == S_QD) && rsp.done;
			req_start_q <= ((state_q == S_IDLE) && start) ||
				(((state_q == S_MOD) || (state_q == S_QN)) && rsp.done);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (rsp.done && rsp.rem == '0) begin
						state_q <= S_QN;
					end
				end
				S_QN: begin
					if (rsp.done) begin
						state_q <= S_QD;
					end
				end
				S_QD: begin
					if (rsp.done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					scaled_q       <= scaled;
					scale_q        <= scale;
					y_q            <= scale;
					req_short_q    <= 1'b0;
					req_dividend_q <= scaled;
					req_divisor_q  <= scale;
				end
			end
			S_MOD: begin
				if (rsp.done) begin
					if (rsp.rem == '0) begin
						req_short_q    <= 1'b0;
						req_dividend_q <= scaled_q;
						req_divisor_q  <= y_q;
					end else begin
						y_q            <= rsp.rem;
						req_short_q    <= 1'b1;
						req_dividend_q <= {{(NUM_W-DEN_W){1'b0}}, y_q};
						req_divisor_q  <= rsp.rem;
					end
				end
			end
			S_QN: begin
				if (rsp.done) begin
					num_q          <= rsp.quo;
					req_short_q    <= 1'b1;
					req_dividend_q <= {{(NUM_W-DEN_W){1'b0}}, scale_q};
					req_divisor_q  <= y_q;
				end
			end
			S_QD: begin
				if (rsp.done) begin
					den_q <= rsp.quo[DEN_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign num_mag = num_q;
	assign den     = den_q;

	`ASSERT_CLK(a_den_nonzero, done_q |-> (den_q != '0), "reduced denominator is zero")
	`ASSERT_CLK(a_start_idle, start |-> (state_q == S_IDLE), "sequencer started while busy")

endmodule

@@ hw/rtl/decimal_to_reduced_fraction_top.sv @@
// Top level of the block that turns a fixed-point value into a reduced fraction.
//
// One beat on the slave side carries a signed fixed-point value; the block scales it by
// the configured denominator with rounding half away from zero, reduces the fraction with
// Euclid's algorithm and delivers one beat with the signed numerator and the positive
// denominator. It works on one value at a time: s_tready is low from acceptance until the
// result has moved into the output register. The one shared restoring divider yields one
// quotient bit per cycle and serves every remainder step of the Euclid loop as well as
// both final divisions. A result waiting in the output register does not block the next
// value.
`include "assert_macros.svh"

module decimal_to_reduced_fraction_top #(
	parameter int FRAC_BITS = drf_pkg::FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [drf_pkg::VALUE_W-1:0]               s_tdata,   // [31:0] value
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [drf_pkg::NUM_W+drf_pkg::DEN_W-1:0]  m_tdata,   // [35:0] numerator, [55:36] denominator
	input  logic                                      cfg_we,
	input  logic [drf_pkg::DEN_W-1:0]                 cfg_wdata
);
	import drf_pkg::*;

	localparam int PROD_W = VALUE_W + DEN_W;
	localparam logic [PROD_W:0] HALF = ({{PROD_W{1'b0}}, 1'b1} << FRAC_BITS) >> 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [DEN_W-1:0]    cfg_scale_q;
	logic [VALUE_W-1:0]  mag_q;
	logic                neg_q;
	logic [DEN_W-1:0]    scale_q;
	logic [PROD_W-1:0]   prod_q;
	logic [NUM_W-1:0]    scaled_q;
	logic                seq_start_q;
	logic                seq_done;
	logic [NUM_W-1:0]    seq_num;
	logic [DEN_W-1:0]    seq_den;
	logic [NUM_W-1:0]    res_num_q;
	logic [DEN_W-1:0]    res_den_q;
	logic                m_valid_q;
	logic [NUM_W-1:0]    m_num_q;
	logic [DEN_W-1:0]    m_den_q;
	logic [VALUE_W-1:0]  in_mag;
	logic [PROD_W:0]     rnd_sum;
	logic [PROD_W:0]     rnd_shift;
	logic [NUM_W-1:0]    rnd_sat;
	logic                in_fire;
	logic                out_free;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;

	assign in_mag    = s_tdata[VALUE_W-1] ? (~s_tdata + VALUE_W'(1)) : s_tdata;
	assign rnd_sum   = {1'b0, prod_q} + HALF;
	assign rnd_shift = rnd_sum >> FRAC_BITS;
	assign rnd_sat   = (rnd_shift > {{(PROD_W+1-NUM_W){1'b0}}, MAG_MAX}) ?
			MAG_MAX : rnd_shift[NUM_W-1:0];

	drf_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (seq_start_q),
		.scaled  (scaled_q),
		.scale   (scale_q),
		.done    (seq_done),
		.num_mag (seq_num),
		.den     (seq_den)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_scale_q <= SCALE_RESET;
			seq_start_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			seq_start_q <= (state_q == ST_RND);
			if (cfg_we) begin
				cfg_scale_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_RND;
				ST_RND: state_q <= ST_RUN;
				ST_RUN: begin
					if (seq_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q   <= in_mag;
			neg_q   <= s_tdata[VALUE_W-1];
			scale_q <= (cfg_scale_q == '0) ? DEN_W'(1) : cfg_scale_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mag_q * scale_q;
		end
		if (state_q == ST_RND) begin
			scaled_q <= rnd_sat;
		end
		if (state_q == ST_RUN && seq_done) begin
			res_num_q <= (neg_q && seq_num != '0) ? (~seq_num + NUM_W'(1)) : seq_num;
			res_den_q <= seq_den;
		end
		if (state_q == ST_DONE && out_free) begin
			m_num_q <= res_num_q;
			m_den_q <= res_den_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_den_q, m_num_q};

	`ASSERT_CLK(a_busy_after_accept, in_fire |=> !s_tready, "accepted a beat while busy")
	`ASSERT_CLK(a_result_loaded, (state_q == ST_DONE && out_free) |=> m_valid_q,
		"finished result not loaded")

endmodule
